[hdl/utf8_stream_decoder_assert.svh]
// assertion macros for the decoder top level
`ifndef UTF8_STREAM_DECODER_ASSERT_SVH
`define UTF8_STREAM_DECODER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define U8DEC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define U8DEC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/u8dec_pkg.sv]
// ----------------------------------------------------------------------------
// u8dec_pkg
// Types and constants shared by the UTF-8 stream decoder modules.
// ----------------------------------------------------------------------------
package u8dec_pkg;

  localparam int BYTE_W  = 8;
  localparam int CP_W    = 21;
  localparam int LEN_W   = 3;
  localparam int BYTES_W = 32;

  // sequence lengths, also used as the open-sequence length
  localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
  localparam logic [LEN_W-1:0] LEN_ONE   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_TWO   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_THREE = 3'd3;
  localparam logic [LEN_W-1:0] LEN_FOUR  = 3'd4;

  // byte prefixes
  localparam logic [1:0] PFX_CONT  = 2'b10;
  localparam logic [2:0] PFX_LEAD2 = 3'b110;
  localparam logic [3:0] PFX_LEAD3 = 4'b1110;
  localparam logic [4:0] PFX_LEAD4 = 5'b11110;

  // payload masks
  localparam logic [BYTE_W-1:0] LEAD2_MASK = 8'h1F;
  localparam logic [BYTE_W-1:0] LEAD3_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] LEAD4_MASK = 8'h07;
  localparam logic [BYTE_W-1:0] CONT_MASK  = 8'h3F;

  localparam int HELD_DEPTH = 3;

  typedef struct packed {
    logic [CP_W-1:0]    char_value;
    logic [LEN_W-1:0]   seq_length;
    logic [BYTES_W-1:0] seq_bytes;
  } result_t;

  typedef struct packed {
    logic    emit;
    result_t res;
  } core_out_t;

endpackage

[hdl/u8dec_core.sv]
// ----------------------------------------------------------------------------
// u8dec_core
// Sequence state and per-byte decode step of the UTF-8 stream decoder.
// ----------------------------------------------------------------------------
module u8dec_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [u8dec_pkg::BYTE_W-1:0]       data_byte,
  input  logic                               advance,
  output u8dec_pkg::core_out_t               core_out
);

  logic [u8dec_pkg::LEN_W-1:0]   exp_len_r, exp_len_nxt;
  logic [u8dec_pkg::LEN_W-1:0]   rcv_len_r, rcv_len_nxt;
  logic [u8dec_pkg::CP_W-1:0]    partial_r, partial_nxt;
  logic [u8dec_pkg::BYTE_W-1:0]  held_r [u8dec_pkg::HELD_DEPTH];
  logic [u8dec_pkg::BYTE_W-1:0]  held_nxt;
  logic                          held_we;
  logic [1:0]                    held_idx;
  logic [u8dec_pkg::CP_W-1:0]    shifted;
  logic [u8dec_pkg::LEN_W-1:0]   rcv_inc;
  logic [u8dec_pkg::BYTES_W-1:0] bytes;

  assign shifted = {partial_r[u8dec_pkg::CP_W-7:0], data_byte[5:0]};
  assign rcv_inc = rcv_len_r + u8dec_pkg::LEN_ONE;

  // gather held bytes of the open sequence plus the closing byte
  always_comb begin
    bytes = '0;
    for (int i = 0; i < u8dec_pkg::HELD_DEPTH; i++) begin
      if (u8dec_pkg::LEN_W'(i) < rcv_len_r) begin
        bytes[8*i +: 8] = held_r[i];
      end
      if (u8dec_pkg::LEN_W'(i + 1) == rcv_len_r) begin
        bytes[8*(i+1) +: 8] = data_byte;
      end
    end
  end

  always_comb begin
    exp_len_nxt = exp_len_r;
    rcv_len_nxt = rcv_len_r;
    partial_nxt = partial_r;
    held_we     = 1'b0;
    held_idx    = rcv_len_r[1:0];
    held_nxt    = data_byte;
    core_out    = '0;
    if (exp_len_r == u8dec_pkg::LEN_NONE) begin
      held_idx = 2'd0;
      priority if (data_byte[7] == 1'b0) begin
        core_out.emit           = 1'b1;
        core_out.res.char_value = u8dec_pkg::CP_W'(data_byte);
        core_out.res.seq_length = u8dec_pkg::LEN_ONE;
        core_out.res.seq_bytes  = u8dec_pkg::BYTES_W'(data_byte);
      end else if (data_byte[7:5] == u8dec_pkg::PFX_LEAD2) begin
        exp_len_nxt = u8dec_pkg::LEN_TWO;
        partial_nxt = u8dec_pkg::CP_W'(data_byte & u8dec_pkg::LEAD2_MASK);
        rcv_len_nxt = u8dec_pkg::LEN_ONE;
        held_we     = 1'b1;
      end else if (data_byte[7:4] == u8dec_pkg::PFX_LEAD3) begin
        exp_len_nxt = u8dec_pkg::LEN_THREE;
        partial_nxt = u8dec_pkg::CP_W'(data_byte & u8dec_pkg::LEAD3_MASK);
        rcv_len_nxt = u8dec_pkg::LEN_ONE;
        held_we     = 1'b1;
      end else if (data_byte[7:3] == u8dec_pkg::PFX_LEAD4) begin
        exp_len_nxt = u8dec_pkg::LEN_FOUR;
        partial_nxt = u8dec_pkg::CP_W'(data_byte & u8dec_pkg::LEAD4_MASK);
        rcv_len_nxt = u8dec_pkg::LEN_ONE;
        held_we     = 1'b1;
      end else begin
        // stray continuation or 11111xxx: dropped
      end
    end else if (data_byte[7:6] != u8dec_pkg::PFX_CONT) begin
      // broken sequence, drop it along with this byte
      exp_len_nxt = u8dec_pkg::LEN_NONE;
      rcv_len_nxt = u8dec_pkg::LEN_NONE;
      partial_nxt = '0;
    end else if (rcv_inc < exp_len_r) begin
      partial_nxt = shifted;
      rcv_len_nxt = rcv_inc;
      held_we     = 1'b1;
    end else begin
      core_out.emit           = 1'b1;
      core_out.res.char_value = shifted;
      core_out.res.seq_length = exp_len_r;
      core_out.res.seq_bytes  = bytes;
      exp_len_nxt = u8dec_pkg::LEN_NONE;
      rcv_len_nxt = u8dec_pkg::LEN_NONE;
      partial_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_len_r <= u8dec_pkg::LEN_NONE;
      rcv_len_r <= u8dec_pkg::LEN_NONE;
      partial_r <= '0;
    end else if (advance) begin
      exp_len_r <= exp_len_nxt;
      rcv_len_r <= rcv_len_nxt;
      partial_r <= partial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && held_we) begin
      held_r[held_idx] <= held_nxt;
    end
  end

endmodule

[hdl/utf8_stream_decoder.sv]
// ----------------------------------------------------------------------------
// utf8_stream_decoder
// Frames a byte stream into UTF-8 sequences and decodes each complete one.
// ----------------------------------------------------------------------------
// Takes one byte per cycle and keeps doing so while results flow out freely.
// An accepted byte sits in an input register and is decoded on its way into
// the result register, so a result shows from the result register after the
// byte that completes its sequence. Bytes that give no result pass through
// even while a result waits; in_stall rises only when the input register
// holds a completing byte and the waiting result is stalled.
`include "utf8_stream_decoder_assert.svh"

module utf8_stream_decoder (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [u8dec_pkg::BYTE_W-1:0]        in_data_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [u8dec_pkg::CP_W-1:0]          out_char_value,
  output logic [u8dec_pkg::LEN_W-1:0]         out_seq_length,
  output logic [u8dec_pkg::BYTES_W-1:0]       out_seq_bytes
);

  logic                           s1_valid_r, s1_valid_nxt;
  logic [u8dec_pkg::BYTE_W-1:0]   s1_byte_r;
  logic                           out_valid_r, out_valid_nxt;
  u8dec_pkg::result_t             res_r;
  u8dec_pkg::core_out_t           core_out;
  logic                           accept;
  logic                           advance;
  logic                           out_blocked;
  logic                           len_ok;
  logic                           one_byte_ok;

  u8dec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .data_byte (s1_byte_r),
    .advance   (advance),
    .core_out  (core_out)
  );

  // an item without a result never waits on the output side
  assign advance  = s1_valid_r && (!core_out.emit || !out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (accept) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance && core_out.emit) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_byte_r <= in_data_byte;
    end
    if (advance && core_out.emit) begin
      res_r <= core_out.res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_char_value = res_r.char_value;
  assign out_seq_length = res_r.seq_length;
  assign out_seq_bytes  = res_r.seq_bytes;

  assign out_blocked = out_valid_r && out_stall;
  assign len_ok      = (out_seq_length >= u8dec_pkg::LEN_ONE) &&
                       (out_seq_length <= u8dec_pkg::LEN_FOUR);
  assign one_byte_ok = (out_seq_length != u8dec_pkg::LEN_ONE) ||
                       ((out_seq_bytes[31:7] == '0) &&
                        (out_char_value == u8dec_pkg::CP_W'(out_seq_bytes[7:0])));

  `U8DEC_ASSERT_NOW(a_len_range, out_valid, len_ok, "result length out of range")
  `U8DEC_ASSERT_NOW(a_ascii_form, out_valid, one_byte_ok, "single-byte result malformed")
  `U8DEC_ASSERT_NOW(a_stall_cause, in_stall, s1_valid_r && out_blocked, "stray input stall")
  `U8DEC_ASSERT_NEXT(a_out_hold, out_blocked, out_valid && $stable(res_r), "held result moved")

endmodule
